[src/bgd_pkg.sv]
// ----------------------------------------------------------------------------
// bgd_pkg
// Shared types and constants for the button gesture detector.
// ----------------------------------------------------------------------------
package bgd_pkg;

    // width of the hold and since-first-press tick counters (8 to 32)
    localparam int TIME_WIDTH = 16;

    localparam int DEB_WIDTH  = 8;
    localparam int LONG_WIDTH = 16;
    localparam int WIN_WIDTH  = 16;

    // compare width wide enough for both counters and registers
    localparam int CMP_WIDTH  = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;

    localparam int CFG_DATA_WIDTH = 16;
    localparam int CFG_IDX_WIDTH  = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE_TICKS      = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_PRESS_TICKS    = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd2;

    localparam logic [DEB_WIDTH-1:0]  DEBOUNCE_RESET = 8'd10;
    localparam logic [LONG_WIDTH-1:0] LONG_RESET     = 16'd2000;
    localparam logic [WIN_WIDTH-1:0]  WINDOW_RESET   = 16'd400;

    typedef struct packed {
        logic [DEB_WIDTH-1:0]  debounce_ticks;
        logic [LONG_WIDTH-1:0] long_press_ticks;
        logic [WIN_WIDTH-1:0]  double_click_window;
    } cfg_t;

    typedef struct packed {
        logic pressed_now;
        logic click_pulse;
        logic long_press_pulse;
        logic double_click_pulse;
    } result_t;

endpackage

[src/bgd_core.sv]
// ----------------------------------------------------------------------------
// bgd_core
// Gesture state registers and the single-tick update logic: debounce,
// click, long-press and double-click detection.
// ----------------------------------------------------------------------------
module bgd_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic             pin_level,
    input  bgd_pkg::cfg_t    cfg,
    output bgd_pkg::result_t result
);
    import bgd_pkg::*;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};
    localparam logic [DEB_WIDTH-1:0]  DEB_MAX  = {DEB_WIDTH{1'b1}};

    logic                  stable_pressed_reg, stable_pressed_next;
    logic [DEB_WIDTH-1:0]  debounce_count_reg, debounce_count_next;
    logic [TIME_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic                  long_reported_reg, long_reported_next;
    logic                  first_pending_reg, first_pending_next;
    logic [TIME_WIDTH-1:0] since_first_reg, since_first_next;
    logic                  second_cand_reg, second_cand_next;

    logic                  raw;
    logic [DEB_WIDTH-1:0]  deb_inc;
    logic [TIME_WIDTH-1:0] since_inc;
    logic [TIME_WIDTH-1:0] hold_inc;
    logic [CMP_WIDTH-1:0]  window_ext;
    logic [CMP_WIDTH-1:0]  long_ext;
    logic                  click, lng, dbl;

    assign raw        = ~pin_level;
    assign deb_inc    = (debounce_count_reg == DEB_MAX) ? DEB_MAX : debounce_count_reg + 1'b1;
    assign since_inc  = (since_first_reg == TIME_MAX) ? TIME_MAX : since_first_reg + 1'b1;
    assign hold_inc   = (hold_count_reg == TIME_MAX) ? TIME_MAX : hold_count_reg + 1'b1;
    assign window_ext = CMP_WIDTH'(cfg.double_click_window);
    assign long_ext   = CMP_WIDTH'(cfg.long_press_ticks);

    always_comb begin
        stable_pressed_next = stable_pressed_reg;
        debounce_count_next = debounce_count_reg;
        hold_count_next     = hold_count_reg;
        long_reported_next  = long_reported_reg;
        first_pending_next  = first_pending_reg;
        since_first_next    = since_inc;
        second_cand_next    = second_cand_reg;
        click               = 1'b0;
        lng                 = 1'b0;
        dbl                 = 1'b0;

        if (!stable_pressed_reg) begin
            if (raw) begin
                if (deb_inc >= cfg.debounce_ticks) begin
                    stable_pressed_next = 1'b1;
                    debounce_count_next = '0;
                    click               = 1'b1;
                    hold_count_next     = TIME_WIDTH'(1);
                    long_reported_next  = 1'b0;
                    if (first_pending_reg && (CMP_WIDTH'(since_inc) <= window_ext)) begin
                        second_cand_next = 1'b1;
                    end else begin
                        // this press starts a fresh window
                        second_cand_next   = 1'b0;
                        first_pending_next = 1'b0;
                        since_first_next   = '0;
                    end
                end else begin
                    debounce_count_next = deb_inc;
                end
            end else begin
                debounce_count_next = '0;
            end
        end else if (raw) begin
            hold_count_next = hold_inc;
        end else begin
            // release takes effect at once
            stable_pressed_next = 1'b0;
            hold_count_next     = '0;
            long_reported_next  = 1'b0;
            if (second_cand_reg) begin
                dbl                = 1'b1;
                first_pending_next = 1'b0;
                second_cand_next   = 1'b0;
            end else if (CMP_WIDTH'(since_inc) <= window_ext) begin
                first_pending_next = 1'b1;
            end
        end

        if (stable_pressed_next && !long_reported_next &&
            (CMP_WIDTH'(hold_count_next) >= long_ext)) begin
            lng                = 1'b1;
            long_reported_next = 1'b1;
        end

        // pending first press expires once the window has passed
        if (first_pending_next && !second_cand_next &&
            (CMP_WIDTH'(since_first_next) > window_ext)) begin
            first_pending_next = 1'b0;
        end
    end

    assign result.pressed_now        = raw;
    assign result.click_pulse        = click;
    assign result.long_press_pulse   = lng;
    assign result.double_click_pulse = dbl;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stable_pressed_reg <= 1'b0;
            debounce_count_reg <= '0;
            hold_count_reg     <= '0;
            long_reported_reg  <= 1'b0;
            first_pending_reg  <= 1'b0;
            since_first_reg    <= '0;
            second_cand_reg    <= 1'b0;
        end else if (step_en) begin
            stable_pressed_reg <= stable_pressed_next;
            debounce_count_reg <= debounce_count_next;
            hold_count_reg     <= hold_count_next;
            long_reported_reg  <= long_reported_next;
            first_pending_reg  <= first_pending_next;
            since_first_reg    <= since_first_next;
            second_cand_reg    <= second_cand_next;
        end
    end

`ifndef SYNTHESIS
    // a confirmed press always carries a nonzero hold count
    assert property (@(posedge aclk) disable iff (!aresetn)
        stable_pressed_reg |-> (hold_count_reg != '0))
        else $error("bgd_core: confirmed press with zero hold count");

    // released state keeps hold count and long flag clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        !stable_pressed_reg |-> (hold_count_reg == '0) && !long_reported_reg)
        else $error("bgd_core: stale hold state while released");

    // a second-press candidate implies a pending first press
    assert property (@(posedge aclk) disable iff (!aresetn)
        second_cand_reg |-> first_pending_reg)
        else $error("bgd_core: second candidate without first press");

    // debounce counting only while not confirmed
    assert property (@(posedge aclk) disable iff (!aresetn)
        stable_pressed_reg |-> (debounce_count_reg == '0))
        else $error("bgd_core: debounce count while confirmed");
`endif

endmodule

[src/button_gesture_detector.sv]
// ----------------------------------------------------------------------------
// button_gesture_detector
// Debounced button with click, long-press and double-click pulses.
// ----------------------------------------------------------------------------
// One input item is one millisecond tick carrying the raw active-low pin
// level; every item yields exactly one result item with the raw pressed
// state and the three gesture pulses. An item is taken every cycle: the
// tick update is a single pass of counter logic into the state registers,
// and the result sits in an output register, so s_ready only drops while a
// result is held and m_ready is low. The user must write registers through
// cfg_wen/cfg_idx/cfg_wdata while no tick is in flight; no check enforces it.
// ----------------------------------------------------------------------------
module button_gesture_detector (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wen,
    input  logic [bgd_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx,
    input  logic [bgd_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_pin_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_pressed_now,
    output logic                                m_click_pulse,
    output logic                                m_long_press_pulse,
    output logic                                m_double_click_pulse
);
    import bgd_pkg::*;

    cfg_t    cfg_reg;
    result_t core_result;
    result_t result_reg;
    logic    m_valid_reg, m_valid_next;
    logic    step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks      <= DEBOUNCE_RESET;
            cfg_reg.long_press_ticks    <= LONG_RESET;
            cfg_reg.double_click_window <= WINDOW_RESET;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                REG_DEBOUNCE_TICKS:
                    cfg_reg.debounce_ticks <= cfg_wdata[DEB_WIDTH-1:0];
                REG_LONG_PRESS_TICKS:
                    cfg_reg.long_press_ticks <= cfg_wdata[LONG_WIDTH-1:0];
                REG_DOUBLE_CLICK_WINDOW:
                    cfg_reg.double_click_window <= cfg_wdata[WIN_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    bgd_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step),
        .pin_level (s_pin_level),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= core_result;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_pressed_now        = result_reg.pressed_now;
    assign m_click_pulse        = result_reg.click_pulse;
    assign m_long_press_pulse   = result_reg.long_press_pulse;
    assign m_double_click_pulse = result_reg.double_click_pulse;

`ifndef SYNTHESIS
    // a click is only reported on a pressed tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_click_pulse |-> m_pressed_now)
        else $error("button_gesture_detector: click on released tick");

    // a double click is only reported on a release tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_double_click_pulse |-> !m_pressed_now)
        else $error("button_gesture_detector: double click on pressed tick");

    // an accepted tick always shows up as a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("button_gesture_detector: accepted tick gave no result");
`endif

endmodule
